@@ hw/rtl/tdss_pkg.sv @@
// tdss_pkg: shared constants, digit code type and segment decode for the
// three-digit seven-segment scanner. no dependencies.
package tdss_pkg;

    localparam int unsigned RAW_W      = 32;
    localparam int unsigned DIV_W      = 16;
    localparam int unsigned NUM_DIGITS = 3;
    localparam int unsigned SEL_W      = 2;
    localparam int unsigned SEG_W      = 7;

    localparam logic [DIV_W-1:0] SCALE_RESET = 16'd10;
    localparam logic [DIV_W-1:0] DISP_LIMIT  = 16'd1000;
    localparam logic [DIV_W-1:0] HUND_LIMIT  = 16'd100;

    typedef logic [3:0] digit_t;

    localparam digit_t BLANK_CODE = 4'd15;

    // active-high pattern, bit0 top through bit6 middle
    function automatic logic [SEG_W-1:0] seg_decode(input digit_t code);
        logic [SEG_W-1:0] seg;
        case (code)
            4'd0:    seg = 7'h3F;
            4'd1:    seg = 7'h06;
            4'd2:    seg = 7'h5B;
            4'd3:    seg = 7'h4F;
            4'd4:    seg = 7'h66;
            4'd5:    seg = 7'h6D;
            4'd6:    seg = 7'h7D;
            4'd7:    seg = 7'h07;
            4'd8:    seg = 7'h7F;
            4'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

@@ hw/rtl/tdss_divider.sv @@
// tdss_divider: restoring radix-2 divider, one quotient bit per cycle.
// 32-bit dividend, 16-bit divisor, low 16 quotient bits out; uses tdss_pkg.
// a zero divisor yields an all-ones quotient.
module tdss_divider
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tdss_pkg::RAW_W-1:0] dividend,
    input  logic [tdss_pkg::DIV_W-1:0] divisor,
    output logic                       done,
    output logic [tdss_pkg::DIV_W-1:0] quotient
);

    logic                       busy_reg;
    logic                       done_reg;
    logic [4:0]                 count_reg;
    logic [tdss_pkg::DIV_W-1:0] rem_reg;
    logic [tdss_pkg::RAW_W-1:0] quo_reg;

    logic [tdss_pkg::DIV_W:0]   shifted;
    logic [tdss_pkg::DIV_W:0]   diff;
    logic                       q_bit;
    logic [tdss_pkg::DIV_W-1:0] rem_next;
    logic [tdss_pkg::RAW_W-1:0] quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[tdss_pkg::RAW_W-1]};
        diff     = shifted - {1'b0, divisor};
        q_bit    = (shifted >= {1'b0, divisor});
        rem_next = q_bit ? diff[tdss_pkg::DIV_W-1:0] : shifted[tdss_pkg::DIV_W-1:0];
        quo_next = {quo_reg[tdss_pkg::RAW_W-2:0], q_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg + 5'd1;
                if (count_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[tdss_pkg::DIV_W-1:0];

endmodule

@@ hw/rtl/three_digit_seven_segment_scanner_top.sv @@
// three_digit_seven_segment_scanner_top: scales a raw temperature, splits it
// into three stored digits and drives one scanned digit per beat.
// depends on tdss_pkg and tdss_divider.
//
//  channel        signals                              dir
//  temp           temp_valid temp_stall temp_raw       in
//  disp           disp_valid disp_stall digit_select   out
//                 segments
//  scale_divisor  scale_divisor_we scale_divisor_wdata in
//
// one beat runs from accept to disp_valid through 32 divider steps, one
// handoff, split, store and emit; a value of 1000 or more skips store.
// the next beat can be accepted the cycle after the emit.
// temp_stall is high from accept until the result is loaded into the output
// register; a held result on disp only delays the next emit.
// reset clears the digits to zero, scan index to 0 and the divisor to 10.
module three_digit_seven_segment_scanner_top
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        temp_valid,
    output logic                        temp_stall,
    input  logic [tdss_pkg::RAW_W-1:0]  temp_raw,
    output logic                        disp_valid,
    input  logic                        disp_stall,
    output logic [tdss_pkg::SEL_W-1:0]  digit_select,
    output logic [tdss_pkg::SEG_W-1:0]  segments,
    input  logic                        scale_divisor_we,
    input  logic [tdss_pkg::DIV_W-1:0]  scale_divisor_wdata
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_DIVIDE,
        ST_SPLIT,
        ST_STORE,
        ST_EMIT
    } state_t;

    state_t                      state_reg;
    logic [tdss_pkg::DIV_W-1:0]  scale_reg;
    tdss_pkg::digit_t            digit_reg [tdss_pkg::NUM_DIGITS];
    logic [tdss_pkg::SEL_W-1:0]  scan_reg;
    logic                        out_valid_reg;
    logic [tdss_pkg::SEL_W-1:0]  sel_reg;
    logic [tdss_pkg::SEG_W-1:0]  seg_reg;
    logic [tdss_pkg::DIV_W-1:0]  value_reg;
    tdss_pkg::digit_t            hund_reg;
    logic [6:0]                  rem_reg;

    logic                        accept;
    logic                        div_done;
    logic [tdss_pkg::DIV_W-1:0]  div_quot;
    logic                        out_free;
    logic [15:0]                 hund_prod;
    tdss_pkg::digit_t            hund_next;
    logic [9:0]                  rem_wide;
    logic [13:0]                 tens_prod;
    tdss_pkg::digit_t            tens_next;
    logic [6:0]                  units_wide;
    logic [tdss_pkg::SEL_W-1:0]  scan_next;

    assign accept   = temp_valid && !temp_stall;
    assign out_free = !out_valid_reg || !disp_stall;

    tdss_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .dividend (temp_raw),
        .divisor  (scale_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // divide by 100 and by 10 through reciprocal multiplies, exact in range
    always_comb
    begin
        hund_prod  = 16'(value_reg[9:0]) * 16'd41;
        hund_next  = hund_prod[15:12];
        rem_wide   = value_reg[9:0] - (10'(hund_next) * 10'd100);
        tens_prod  = 14'(rem_reg) * 14'd103;
        tens_next  = tens_prod[13:10];
        units_wide = rem_reg - (7'(tens_next) * 7'd10);
        scan_next  = (scan_reg == 2'(tdss_pkg::NUM_DIGITS - 1)) ? '0 : scan_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scale_reg     <= tdss_pkg::SCALE_RESET;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < tdss_pkg::NUM_DIGITS; i++)
            begin
                digit_reg[i] <= '0;
            end
        end
        else
        begin
            if (scale_divisor_we)
            begin
                scale_reg <= scale_divisor_wdata;
            end
            if (out_valid_reg && !disp_stall && state_reg != ST_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_SPLIT;
                    end
                end
                ST_SPLIT:
                begin
                    state_reg <= (value_reg >= tdss_pkg::DISP_LIMIT) ? ST_EMIT : ST_STORE;
                end
                ST_STORE:
                begin
                    digit_reg[0] <= (value_reg >= tdss_pkg::HUND_LIMIT) ? hund_reg
                                                                        : tdss_pkg::BLANK_CODE;
                    digit_reg[1] <= tens_next;
                    digit_reg[2] <= units_wide[3:0];
                    state_reg    <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        scan_reg      <= scan_next;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIVIDE && div_done)
        begin
            value_reg <= div_quot;
        end
        if (state_reg == ST_SPLIT)
        begin
            hund_reg <= hund_next;
            rem_reg  <= rem_wide[6:0];
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            sel_reg <= scan_reg;
            seg_reg <= tdss_pkg::seg_decode(digit_reg[scan_reg]);
        end
    end

    assign temp_stall   = (state_reg != ST_IDLE);
    assign disp_valid   = out_valid_reg;
    assign digit_select = sel_reg;
    assign segments     = seg_reg;

endmodule
